>>> hw/rtl/lpfd_pkg.sv
// Package with the result kinds, the result record and the fixed constants of the deframer.
`default_nettype none
package lpfd_pkg;

    // Number of bytes in the big-endian length prefix.
    localparam int unsigned PREFIX_BYTES = 4;
    localparam int unsigned PCNT_W       = 3;

    localparam int unsigned LEN_W        = 32;
    localparam int unsigned MIN_LEN_W    = 17;
    localparam int unsigned BYTE_W       = 8;

    localparam logic [LEN_W-1:0]     MAX_LEN_RESET = 32'd65536;
    localparam logic [MIN_LEN_W-1:0] MIN_LEN_RESET = 17'd16;

    typedef enum logic {
        CFG_MAX_FRAME_LEN = 1'b0,
        CFG_MIN_FRAME_LEN = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KIND_PREFIX  = 2'd0,
        KIND_FRAME   = 2'd1,
        KIND_BAD_LEN = 2'd2,
        KIND_REJECT  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [BYTE_W-1:0]  frame_byte;
        logic               frame_last;
        logic [LEN_W-1:0]   frame_len;
    } t_result;

endpackage
`default_nettype wire

>>> hw/rtl/lpfd_core.sv
// Deframing state: prefix gathering, length check, frame byte counting and sticky fault.
`default_nettype none
module lpfd_core #(
    parameter int unsigned MAX_FRAME_BYTES = 65536
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_accept,
    input  wire logic [lpfd_pkg::BYTE_W-1:0]     i_byte,
    input  wire logic [lpfd_pkg::LEN_W-1:0]      i_max_len,
    input  wire logic [lpfd_pkg::MIN_LEN_W-1:0]  i_min_len,
    output lpfd_pkg::t_result                    o_result
);

    localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES + 1);

    logic [lpfd_pkg::PCNT_W-1:0] r_count, n_count;
    logic [lpfd_pkg::LEN_W-1:0]  r_shift, n_shift;
    logic [CNT_W-1:0]            r_bytes, n_bytes;
    logic                        r_fault, n_fault;
    logic [CNT_W-1:0]            cnt_inc;
    logic                        bad_len;

    assign cnt_inc = r_bytes + 1'b1;

    always_comb begin
        n_count = r_count;
        n_shift = r_shift;
        n_bytes = r_bytes;
        n_fault = r_fault;
        bad_len = 1'b0;
        o_result.kind       = lpfd_pkg::KIND_REJECT;
        o_result.frame_byte = '0;
        o_result.frame_last = 1'b0;
        o_result.frame_len  = r_shift;
        if (r_fault) begin
            o_result.kind = lpfd_pkg::KIND_REJECT;
        end else if (r_count < lpfd_pkg::PCNT_W'(lpfd_pkg::PREFIX_BYTES)) begin
            if (r_count == '0) begin
                n_shift = {{(lpfd_pkg::LEN_W - lpfd_pkg::BYTE_W){1'b0}}, i_byte};
            end else begin
                n_shift = {r_shift[lpfd_pkg::LEN_W-lpfd_pkg::BYTE_W-1:0], i_byte};
            end
            bad_len = (n_shift < {{(lpfd_pkg::LEN_W - lpfd_pkg::MIN_LEN_W){1'b0}}, i_min_len})
                   || (n_shift > i_max_len)
                   || (n_shift > lpfd_pkg::LEN_W'(MAX_FRAME_BYTES));
            n_count = r_count + 1'b1;
            o_result.frame_len = n_shift;
            o_result.kind      = lpfd_pkg::KIND_PREFIX;
            if (n_count == lpfd_pkg::PCNT_W'(lpfd_pkg::PREFIX_BYTES)) begin
                if (bad_len) begin
                    n_fault       = 1'b1;
                    o_result.kind = lpfd_pkg::KIND_BAD_LEN;
                end else begin
                    n_bytes = '0;
                    // An empty frame ends as soon as its prefix is complete.
                    if (n_shift == '0) begin
                        n_count = '0;
                    end
                end
            end
        end else begin
            o_result.kind       = lpfd_pkg::KIND_FRAME;
            o_result.frame_byte = i_byte;
            if ({{(lpfd_pkg::LEN_W - CNT_W){1'b0}}, cnt_inc} >= r_shift) begin
                o_result.frame_last = 1'b1;
                n_count = '0;
                n_bytes = '0;
            end else begin
                n_bytes = cnt_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_shift <= '0;
            r_bytes <= '0;
            r_fault <= 1'b0;
        end else if (i_accept) begin
            r_count <= n_count;
            r_shift <= n_shift;
            r_bytes <= n_bytes;
            r_fault <= n_fault;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/lpfd_skid.sv
// Output register with a skid stage so the input side keeps moving while a result waits.
`default_nettype none
module lpfd_skid (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire lpfd_pkg::t_result  i_data,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output lpfd_pkg::t_result       o_data
);

    logic              r_out_valid, n_out_valid;
    logic              r_skid_valid, n_skid_valid;
    lpfd_pkg::t_result r_out, n_out;
    lpfd_pkg::t_result r_skid, n_skid;
    logic              take_in;
    logic              take_out;

    assign o_ready  = !r_skid_valid;
    assign take_in  = i_valid && !r_skid_valid;
    assign take_out = r_out_valid && i_ready;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (take_out) begin
            n_out_valid = 1'b0;
        end
        if (r_skid_valid && !n_out_valid) begin
            // The parked item moves up first to keep order.
            n_out        = r_skid;
            n_out_valid  = 1'b1;
            n_skid_valid = 1'b0;
        end
        if (take_in) begin
            if (!n_out_valid) begin
                n_out       = i_data;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = i_data;
                n_skid_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

endmodule
`default_nettype wire

>>> hw/rtl/length_prefixed_frame_deframer.sv
// Top level of the length-prefixed frame deframer.
// One received byte is accepted per cycle while the skid stage is empty, and gives exactly
// one result item; the state update and length compare sit in a single combinational step
// ahead of the output register. A skid stage takes one more item while a result waits; input
// then pauses until the parked item has moved into the output register. The first four bytes
// of each frame form a big-endian length; a length outside the allowed range faults the
// block until reset, and every later byte is answered as rejected.
// Configuration registers: index 0 is max_frame_len, index 1 is min_frame_len.
`default_nettype none
module length_prefixed_frame_deframer #(
    parameter int unsigned MAX_FRAME_BYTES = 65536
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write channel.
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    // Input stream; tdata: in_byte[7:0].
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,
    // Result stream; tdata: frame_byte[7:0], frame_len[39:8]. tuser: kind[1:0].
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,
    output logic             m_axis_tlast,
    output logic [1:0]       m_axis_tuser
);

    logic [lpfd_pkg::LEN_W-1:0]     r_max_len;
    logic [lpfd_pkg::MIN_LEN_W-1:0] r_min_len;
    logic                           accept;
    lpfd_pkg::t_result              core_res;
    lpfd_pkg::t_result              out_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= lpfd_pkg::MAX_LEN_RESET;
            r_min_len <= lpfd_pkg::MIN_LEN_RESET;
        end else if (i_cfg_valid) begin
            case (lpfd_pkg::t_cfg_idx'(i_cfg_index))
                lpfd_pkg::CFG_MAX_FRAME_LEN: r_max_len <= i_cfg_data;
                lpfd_pkg::CFG_MIN_FRAME_LEN: r_min_len <= i_cfg_data[lpfd_pkg::MIN_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign accept = s_axis_tvalid && s_axis_tready;

    lpfd_core #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_byte    (s_axis_tdata),
        .i_max_len (r_max_len),
        .i_min_len (r_min_len),
        .o_result  (core_res)
    );

    lpfd_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (core_res),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (out_res)
    );

    assign m_axis_tdata = {out_res.frame_len, out_res.frame_byte};
    assign m_axis_tlast = out_res.frame_last;
    assign m_axis_tuser = out_res.kind;

endmodule
`default_nettype wire

>>> bench/tb_top.sv
// Self-checking testbench for the length-prefixed frame deframer.
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned FRAME_CAP   = 65536;
    localparam int unsigned CYCLE_LIMIT = 1000000;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index   = lpfd_pkg::CFG_MAX_FRAME_LEN;
    logic [31:0] i_cfg_data    = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic [1:0]  m_axis_tuser;

    length_prefixed_frame_deframer #(
        .MAX_FRAME_BYTES(FRAME_CAP)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser)
    );

    // Bytes waiting to be sent and results waiting to be seen.
    logic [7:0]        byte_q[$];
    lpfd_pkg::t_result expected_q[$];

    // Mirror of the deframer state and its registers.
    logic [31:0]                    mirror_max_len = lpfd_pkg::MAX_LEN_RESET;
    logic [lpfd_pkg::MIN_LEN_W-1:0] mirror_min_len = lpfd_pkg::MIN_LEN_RESET;
    int unsigned                    prefix_seen    = 0;
    logic [31:0]                    decoded_len    = '0;
    int unsigned                    payload_seen   = 0;
    bit                             link_faulted   = 1'b0;

    int unsigned send_gap_pct    = 0;
    int unsigned recv_stall_pct  = 0;
    int unsigned bytes_queued    = 0;
    int unsigned results_checked = 0;
    int unsigned frames_closed   = 0;
    int unsigned error_count     = 0;
    int unsigned cycle_count     = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Works out the result that one received byte should produce.
    function automatic lpfd_pkg::t_result deframe_byte(input logic [7:0] rx_byte);
        lpfd_pkg::t_result res;
        res.kind       = lpfd_pkg::KIND_PREFIX;
        res.frame_byte = '0;
        res.frame_last = 1'b0;
        if (link_faulted) begin
            res.kind = lpfd_pkg::KIND_REJECT;
        end else if (prefix_seen < lpfd_pkg::PREFIX_BYTES) begin
            decoded_len = (prefix_seen == 0) ? {24'd0, rx_byte} : {decoded_len[23:0], rx_byte};
            prefix_seen++;
            if (prefix_seen == lpfd_pkg::PREFIX_BYTES) begin
                if (decoded_len < {15'd0, mirror_min_len} || decoded_len > mirror_max_len ||
                    decoded_len > FRAME_CAP) begin
                    link_faulted = 1'b1;
                    res.kind     = lpfd_pkg::KIND_BAD_LEN;
                end else begin
                    payload_seen = 0;
                    // An empty frame closes as soon as its prefix is complete.
                    if (decoded_len == 0)
                        prefix_seen = 0;
                end
            end
        end else begin
            payload_seen++;
            res.kind       = lpfd_pkg::KIND_FRAME;
            res.frame_byte = rx_byte;
            if (payload_seen >= decoded_len) begin
                res.frame_last = 1'b1;
                prefix_seen    = 0;
                payload_seen   = 0;
            end
        end
        res.frame_len = decoded_len;
        return res;
    endfunction

    // Driver: presents queued bytes with random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                expected_q.push_back(deframe_byte(s_axis_tdata));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (byte_q.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= byte_q.pop_front();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result item against the oldest expectation.
    always @(posedge i_clk) begin
        lpfd_pkg::t_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_q.size() == 0) begin
                    $error("result item with no expectation waiting");
                    error_count++;
                end else begin
                    want = expected_q.pop_front();
                    results_checked++;
                    if (want.frame_last)
                        frames_closed++;
                    if (m_axis_tuser != want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, m_axis_tuser);
                        error_count++;
                    end
                    if (m_axis_tdata[7:0] != want.frame_byte) begin
                        $error("frame_byte: expected %0h, got %0h",
                               want.frame_byte, m_axis_tdata[7:0]);
                        error_count++;
                    end
                    if (m_axis_tlast != want.frame_last) begin
                        $error("frame_last: expected %0d, got %0d", want.frame_last, m_axis_tlast);
                        error_count++;
                    end
                    if (m_axis_tdata[39:8] != want.frame_len) begin
                        $error("frame_len: expected %0h, got %0h",
                               want.frame_len, m_axis_tdata[39:8]);
                        error_count++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic push_prefix(input logic [31:0] len);
        byte_q.push_back(len[31:24]);
        byte_q.push_back(len[23:16]);
        byte_q.push_back(len[15:8]);
        byte_q.push_back(len[7:0]);
        bytes_queued += 4;
    endtask

    task automatic push_frame(input int unsigned len);
        push_prefix(len);
        for (int unsigned i = 0; i < len; i++)
            byte_q.push_back(8'($urandom_range(255)));
        bytes_queued += len;
    endtask

    // Waits until every queued byte has gone in and every result has come out.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (byte_q.size() > 0 || s_axis_tvalid || expected_q.size() > 0);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic cfg_write(input lpfd_pkg::t_cfg_idx idx, input logic [31:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == lpfd_pkg::CFG_MAX_FRAME_LEN)
            mirror_max_len = value;
        else
            mirror_min_len = value[lpfd_pkg::MIN_LEN_W-1:0];
        @(negedge i_clk);
    endtask

    initial begin
        int unsigned target;
        int unsigned len;
        int unsigned fault_case;
        logic [31:0] bad_len;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings, slow sender and slower receiver.
        send_gap_pct   = 38;
        recv_stall_pct = 59;
        push_prefix(16);
        for (int i = 0; i < 16; i++)
            byte_q.push_back((i % 2 == 0) ? 8'h00 : 8'hFF);
        bytes_queued += 16;
        target = bytes_queued + 120;
        while (bytes_queued < target)
            push_frame($urandom_range(16, 40));
        wait_drained();

        // Open limits with zero length allowed; roles of the two sides swapped.
        send_gap_pct   = 59;
        recv_stall_pct = 38;
        cfg_write(lpfd_pkg::CFG_MAX_FRAME_LEN, 32'hFFFF_FFFF);
        cfg_write(lpfd_pkg::CFG_MIN_FRAME_LEN, 32'd0);
        push_frame(0);
        push_prefix(1);
        byte_q.push_back(8'hFF);
        bytes_queued += 1;
        target = bytes_queued + 50;
        while (bytes_queued < target)
            push_frame(($urandom_range(3) == 0) ? 0 : $urandom_range(1, 24));
        // Hold the sender in the middle of a prefix until everything has drained.
        len = $urandom_range(1, 24);
        byte_q.push_back(8'h00);
        byte_q.push_back(8'h00);
        bytes_queued += 2;
        wait_drained();
        byte_q.push_back(8'h00);
        byte_q.push_back(len[7:0]);
        for (int unsigned i = 0; i < len; i++)
            byte_q.push_back(8'($urandom_range(255)));
        bytes_queued += 2 + len;
        target = bytes_queued + 50;
        while (bytes_queued < target)
            push_frame(($urandom_range(3) == 0) ? 0 : $urandom_range(1, 24));
        wait_drained();

        // Both limits at zero: only empty frames pass.
        cfg_write(lpfd_pkg::CFG_MAX_FRAME_LEN, 32'd0);
        for (int i = 0; i < 15; i++)
            push_frame(0);
        wait_drained();

        // From here on neither side idles.
        send_gap_pct   = 0;
        recv_stall_pct = 0;

        // Minimum and maximum at the same length: only that length passes.
        cfg_write(lpfd_pkg::CFG_MAX_FRAME_LEN, 32'd100);
        cfg_write(lpfd_pkg::CFG_MIN_FRAME_LEN, 32'd100);
        push_frame(100);
        wait_drained();

        // Moderate window, mostly short frames with the odd long one.
        cfg_write(lpfd_pkg::CFG_MAX_FRAME_LEN, 32'd64);
        cfg_write(lpfd_pkg::CFG_MIN_FRAME_LEN, 32'd1);
        push_frame(64);
        target = bytes_queued + 60;
        while (bytes_queued < target)
            push_frame(($urandom_range(9) == 0) ? $urandom_range(31, 64) : $urandom_range(1, 30));
        wait_drained();

        // The fault is sticky, so one bad length ends the run.
        fault_case = $urandom_range(2);
        cfg_write(lpfd_pkg::CFG_MIN_FRAME_LEN, 32'd16);
        if (fault_case == 0) begin
            cfg_write(lpfd_pkg::CFG_MAX_FRAME_LEN, 32'd1000);
            bad_len = $urandom_range(0, 15);
        end else if (fault_case == 1) begin
            cfg_write(lpfd_pkg::CFG_MAX_FRAME_LEN, 32'd1000);
            bad_len = $urandom_range(1001, FRAME_CAP);
        end else begin
            cfg_write(lpfd_pkg::CFG_MAX_FRAME_LEN, 32'hFFFF_FFFF);
            bad_len = ($urandom_range(1) == 0) ? 32'hFFFF_FFFF
                                               : $urandom_range(FRAME_CAP + 1, 32'hFFFF_FFFF);
        end
        push_frame(20);
        push_prefix(bad_len);
        for (int i = 0; i < 40; i++)
            byte_q.push_back(8'($urandom_range(255)));
        bytes_queued += 40;
        wait_drained();
        repeat (10) @(negedge i_clk);

        $display("Sent %0d bytes over six register settings; %0d results checked, %0d frames closed.",
                 bytes_queued, results_checked, frames_closed);
        $display("Run ended with a sticky length fault (case %0d: %s) and rejected bytes after it.",
                 fault_case, (fault_case == 0) ? "below minimum" :
                 (fault_case == 1) ? "above configured maximum" : "above built-in maximum");
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
